// ===== rtl/imh_pkg.sv =====
// Package for the indexed min-heap core: sizes, command and status codes,
// transaction structs. No dependencies.
`timescale 1ns / 1ps
package imh_pkg;

    localparam int HEAP_CAPACITY = 1024;
    localparam int MAX_HANDLES   = 4096;
    localparam int SLOT_AW       = $clog2(HEAP_CAPACITY);
    localparam int SLOT_W        = SLOT_AW + 1;
    localparam int HND_AW        = $clog2(MAX_HANDLES);
    localparam int HND_W         = HND_AW + 1;

    localparam logic [2:0] CMD_PEEK    = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_DEL_MIN = 3'd2;
    localparam logic [2:0] CMD_DEL_HND = 3'd3;
    localparam logic [2:0] CMD_MODIFY  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DEAD  = 2'd3;

    typedef struct packed {
        logic [2:0]        command;
        logic [12:0]       handle;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic               is_empty;
        logic [10:0]        element_count;
        logic [12:0]        new_handle;
        logic [1:0]         status;
    } rsp_t;

endpackage

// ===== rtl/imh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module imh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/indexed_min_heap_core.sv =====
// Indexed min-heap core: sequencer, signed value compares and heap/handle stores.
// Depends on imh_pkg and imh_ram.
`timescale 1ns / 1ps
// Usage:
//   cmd channel (cmd_valid/cmd_stall, payload cmd) carries one command per
//   transaction: peek, insert, delete minimum, delete handle, modify handle.
//   rsp channel (rsp_valid/rsp_stall, payload rsp) returns exactly one
//   transaction per command: minimum, empty flag, count, new handle, status.
//   One command is in work at a time; cmd_stall is high from acceptance
//   until the response is loaded into the output register.
//   Per heap level walked, a sift up reads the parent and compares, and a
//   sift down reads the children, compares, decides and moves.
//   Each level costs one read of the value store per child or parent, one
//   signed compare per value read and one write-back through the stores.
//   The next command is accepted while a response waits in the output
//   register; a stalled response holds and the core waits before loading
//   the following one.
//   Reset clears size, handle counter and control; handle liveness is
//   qualified by the handle counter, so no clearing pass is needed.
module indexed_min_heap_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  imh_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output imh_pkg::rsp_t rsp
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_OWN    = 4'd3;
    localparam logic [3:0] S_DLIVE  = 4'd4;
    localparam logic [3:0] S_DLAST  = 4'd5;
    localparam logic [3:0] S_DNRD   = 4'd6;
    localparam logic [3:0] S_DNL    = 4'd7;
    localparam logic [3:0] S_DNR    = 4'd8;
    localparam logic [3:0] S_DNDEC  = 4'd9;
    localparam logic [3:0] S_DNMV   = 4'd10;
    localparam logic [3:0] S_UPRD   = 4'd11;
    localparam logic [3:0] S_UPCMP  = 4'd12;
    localparam logic [3:0] S_PLACE  = 4'd13;
    localparam logic [3:0] S_TOP    = 4'd14;
    localparam logic [3:0] S_TOPD   = 4'd15;

    localparam int SAW = imh_pkg::SLOT_AW;
    localparam int SW  = imh_pkg::SLOT_W;
    localparam int HAW = imh_pkg::HND_AW;
    localparam int HW  = imh_pkg::HND_W;

    logic [3:0]         state_reg, state_next;
    logic [2:0]         cmdc_reg, cmdc_next;
    logic [HW-1:0]      h_reg, h_next;
    logic signed [31:0] x_reg, x_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [SW-1:0]      best_reg, best_next;
    logic signed [31:0] bestv_reg, bestv_next;
    logic signed [31:0] cv_reg, cv_next;
    logic [HW-1:0]      co_reg, co_next;
    logic               moved_reg, moved_next;
    logic [SW-1:0]      size_reg, size_next;
    logic [HW-1:0]      cnt_reg, cnt_next;
    logic [1:0]         status_reg, status_next;
    logic [HW-1:0]      newh_reg, newh_next;
    imh_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               v_we, o_we, s_we, l_we;
    logic [SAW-1:0]     v_raddr, o_raddr, slot_waddr;
    logic [HAW-1:0]     s_waddr, l_waddr, hnd_raddr;
    logic [31:0]        v_rdata;
    logic signed [31:0] v_rd;
    logic [31:0]        v_wdata;
    logic [HW-1:0]      o_rdata, o_wdata;
    logic [SW-1:0]      s_rdata;
    logic               l_wdata, l_rdata;

    logic [SW:0]        lch, rch, size_x;
    logic [SW-1:0]      par;
    logic               cmd_acc;

    assign v_rd    = $signed(v_rdata);
    assign lch     = {s_reg, 1'b0};
    assign rch     = {s_reg, 1'b1};
    assign size_x  = {1'b0, size_reg};
    assign par     = s_reg >> 1;
    assign cmd_acc = cmd_valid && !cmd_stall;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign slot_waddr = SAW'(s_reg - SW'(1));
    assign hnd_raddr  = HAW'(h_reg - HW'(1));

    imh_ram #(.WIDTH(32), .DEPTH(imh_pkg::HEAP_CAPACITY)) u_vals (
        .clk(clk), .we(v_we), .waddr(slot_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    imh_ram #(.WIDTH(HW), .DEPTH(imh_pkg::HEAP_CAPACITY)) u_owner (
        .clk(clk), .we(o_we), .waddr(slot_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    imh_ram #(.WIDTH(SW), .DEPTH(imh_pkg::MAX_HANDLES)) u_hslot (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_reg),
        .raddr(hnd_raddr), .rdata(s_rdata)
    );

    imh_ram #(.WIDTH(1), .DEPTH(imh_pkg::MAX_HANDLES)) u_live (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(hnd_raddr), .rdata(l_rdata)
    );

    // store port selection
    always_comb
    begin
        v_raddr = '0;
        o_raddr = '0;
        v_we    = 1'b0;
        o_we    = 1'b0;
        s_we    = 1'b0;
        l_we    = 1'b0;
        v_wdata = v_rdata;
        o_wdata = o_rdata;
        s_waddr = HAW'(o_rdata - HW'(1));
        l_waddr = hnd_raddr;
        l_wdata = 1'b0;
        case (state_reg)
            S_DNRD:  v_raddr = SAW'(lch - (SW+1)'(1));
            S_DNL:   v_raddr = SAW'(rch - (SW+1)'(1));
            S_DNDEC: o_raddr = SAW'(best_reg - SW'(1));
            S_UPRD:
            begin
                v_raddr = SAW'(par - SW'(1));
                o_raddr = SAW'(par - SW'(1));
            end
            S_DLIVE:
            begin
                v_raddr = SAW'(size_reg - SW'(1));
                o_raddr = SAW'(size_reg - SW'(1));
                l_we    = 1'b1;
            end
            S_DNMV:
            begin
                v_we    = 1'b1;
                o_we    = 1'b1;
                s_we    = 1'b1;
                v_wdata = bestv_reg;
            end
            S_UPCMP:
            begin
                v_we = (v_rd > cv_reg);
                o_we = (v_rd > cv_reg);
                s_we = (v_rd > cv_reg);
            end
            S_PLACE:
            begin
                v_we    = 1'b1;
                o_we    = 1'b1;
                s_we    = 1'b1;
                v_wdata = cv_reg;
                o_wdata = co_reg;
                s_waddr = HAW'(co_reg - HW'(1));
                l_we    = (cmdc_reg == imh_pkg::CMD_INSERT);
                l_waddr = HAW'(co_reg - HW'(1));
                l_wdata = 1'b1;
            end
            default:
            begin
                v_raddr = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmdc_next      = cmdc_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        s_next         = s_reg;
        best_next      = best_reg;
        bestv_next     = bestv_reg;
        cv_next        = cv_reg;
        co_next        = co_reg;
        moved_next     = moved_reg;
        size_next      = size_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        newh_next      = newh_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    cmdc_next   = cmd.command;
                    h_next      = cmd.handle;
                    x_next      = cmd.value;
                    status_next = imh_pkg::ST_OK;
                    newh_next   = '0;
                    moved_next  = 1'b0;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (cmdc_reg)
                    imh_pkg::CMD_INSERT:
                    begin
                        if (size_reg == SW'(imh_pkg::HEAP_CAPACITY) ||
                            cnt_reg == HW'(imh_pkg::MAX_HANDLES))
                        begin
                            status_next = imh_pkg::ST_FULL;
                            state_next  = S_TOP;
                        end
                        else
                        begin
                            size_next  = size_reg + SW'(1);
                            cnt_next   = cnt_reg + HW'(1);
                            s_next     = size_reg + SW'(1);
                            co_next    = cnt_reg + HW'(1);
                            newh_next  = cnt_reg + HW'(1);
                            cv_next    = x_reg;
                            state_next = S_UPRD;
                        end
                    end
                    imh_pkg::CMD_DEL_MIN:
                    begin
                        if (size_reg == '0)
                        begin
                            status_next = imh_pkg::ST_EMPTY;
                            state_next  = S_TOP;
                        end
                        else
                        begin
                            s_next     = SW'(1);
                            state_next = S_OWN;
                        end
                    end
                    imh_pkg::CMD_DEL_HND, imh_pkg::CMD_MODIFY:
                    begin
                        state_next = S_CHK;
                    end
                    default:
                    begin
                        if (size_reg == '0)
                        begin
                            status_next = imh_pkg::ST_EMPTY;
                        end
                        state_next = S_TOP;
                    end
                endcase
            end
            S_CHK:
            begin
                if (h_reg == '0 || h_reg > cnt_reg || !l_rdata)
                begin
                    status_next = imh_pkg::ST_DEAD;
                    state_next  = S_TOP;
                end
                else
                begin
                    s_next = s_rdata;
                    if (cmdc_reg == imh_pkg::CMD_MODIFY)
                    begin
                        cv_next    = x_reg;
                        co_next    = h_reg;
                        state_next = S_DNRD;
                    end
                    else
                    begin
                        state_next = S_DLIVE;
                    end
                end
            end
            S_OWN:
            begin
                h_next     = o_rdata;
                state_next = S_DLIVE;
            end
            S_DLIVE:
            begin
                state_next = S_DLAST;
            end
            S_DLAST:
            begin
                cv_next   = v_rd;
                co_next   = o_rdata;
                size_next = size_reg - SW'(1);
                if (s_reg == size_reg)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_DNRD;
                end
            end
            S_DNRD:
            begin
                if (lch > size_x)
                begin
                    state_next = moved_reg ? S_PLACE : S_UPRD;
                end
                else
                begin
                    state_next = S_DNL;
                end
            end
            S_DNL:
            begin
                if (v_rd < cv_reg)
                begin
                    best_next  = SW'(lch);
                    bestv_next = v_rd;
                end
                else
                begin
                    best_next  = s_reg;
                    bestv_next = cv_reg;
                end
                state_next = (rch > size_x) ? S_DNDEC : S_DNR;
            end
            S_DNR:
            begin
                if (v_rd < bestv_reg)
                begin
                    best_next  = SW'(rch);
                    bestv_next = v_rd;
                end
                state_next = S_DNDEC;
            end
            S_DNDEC:
            begin
                if (best_reg == s_reg)
                begin
                    state_next = moved_reg ? S_PLACE : S_UPRD;
                end
                else
                begin
                    state_next = S_DNMV;
                end
            end
            S_DNMV:
            begin
                s_next     = best_reg;
                moved_next = 1'b1;
                state_next = S_DNRD;
            end
            S_UPRD:
            begin
                state_next = (s_reg == SW'(1)) ? S_PLACE : S_UPCMP;
            end
            S_UPCMP:
            begin
                if (v_rd > cv_reg)
                begin
                    s_next     = par;
                    state_next = S_UPRD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                state_next = S_TOP;
            end
            S_TOP:
            begin
                state_next = S_TOPD;
            end
            S_TOPD:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.min_value     = (size_reg == '0) ? 32'sd0 : v_rd;
                    rsp_next.is_empty      = (size_reg == '0);
                    rsp_next.element_count = size_reg;
                    rsp_next.new_handle    = newh_reg;
                    rsp_next.status        = status_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmdc_reg   <= cmdc_next;
        h_reg      <= h_next;
        x_reg      <= x_next;
        s_reg      <= s_next;
        best_reg   <= best_next;
        bestv_reg  <= bestv_next;
        cv_reg     <= cv_next;
        co_reg     <= co_next;
        moved_reg  <= moved_next;
        status_reg <= status_next;
        newh_reg   <= newh_next;
        rsp_reg    <= rsp_next;
    end

endmodule

// ===== verif/indexed_min_heap_core_test.sv =====
// Testbench for indexed_min_heap_core: directed, random and capacity tests
// checked against an in-bench heap predictor.
// Depends on imh_pkg and the core RTL.
`timescale 1ns / 1ps
module indexed_min_heap_core_test;

    localparam int IDLE_LIMIT = 20000;

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_stall;
    imh_pkg::cmd_t  cmd;
    logic           rsp_valid;
    logic           rsp_stall;
    imh_pkg::rsp_t  rsp;

    indexed_min_heap_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // heap predictor state
    int          heap_val [1:imh_pkg::HEAP_CAPACITY];
    int          slot_hnd [1:imh_pkg::HEAP_CAPACITY];
    int          hnd_slot [1:imh_pkg::MAX_HANDLES];
    bit          hnd_live [0:imh_pkg::MAX_HANDLES];
    int          heap_count;
    int          last_handle;

    imh_pkg::rsp_t expected_rsp_q[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    bit          sending_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void swap_slots(int a, int b);
        int ha;
        int hb;
        int v;
        ha = slot_hnd[a];
        hb = slot_hnd[b];
        hnd_slot[ha] = b;
        hnd_slot[hb] = a;
        slot_hnd[a] = hb;
        slot_hnd[b] = ha;
        v = heap_val[a];
        heap_val[a] = heap_val[b];
        heap_val[b] = v;
    endfunction

    function automatic void sink(int s);
        int best;
        forever
        begin
            best = s;
            if (2 * s <= heap_count && heap_val[2 * s] < heap_val[best])
                best = 2 * s;
            if (2 * s + 1 <= heap_count && heap_val[2 * s + 1] < heap_val[best])
                best = 2 * s + 1;
            if (best == s)
                return;
            swap_slots(s, best);
            s = best;
        end
    endfunction

    function automatic void swim(int s);
        while (s > 1 && heap_val[s / 2] > heap_val[s])
        begin
            swap_slots(s / 2, s);
            s = s / 2;
        end
    endfunction

    function automatic void remove_at(int s);
        hnd_live[slot_hnd[s]] = 1'b0;
        swap_slots(s, heap_count);
        heap_count--;
        if (s <= heap_count)
        begin
            sink(s);
            swim(s);
        end
    endfunction

    function automatic bit handle_live(int h);
        return h >= 1 && h <= imh_pkg::MAX_HANDLES && hnd_live[h];
    endfunction

    function automatic imh_pkg::rsp_t heap_apply(imh_pkg::cmd_t c);
        imh_pkg::rsp_t r;
        int   h;
        int   s;
        r = '0;
        h = int'(c.handle);
        r.status = imh_pkg::ST_OK;
        case (c.command)
            imh_pkg::CMD_INSERT:
            begin
                if (heap_count >= imh_pkg::HEAP_CAPACITY ||
                    last_handle >= imh_pkg::MAX_HANDLES)
                    r.status = imh_pkg::ST_FULL;
                else
                begin
                    heap_count++;
                    last_handle++;
                    hnd_slot[last_handle] = heap_count;
                    hnd_live[last_handle] = 1'b1;
                    slot_hnd[heap_count] = last_handle;
                    heap_val[heap_count] = int'(c.value);
                    swim(heap_count);
                    r.new_handle = 13'(last_handle);
                end
            end
            imh_pkg::CMD_DEL_MIN:
            begin
                if (heap_count == 0)
                    r.status = imh_pkg::ST_EMPTY;
                else
                    remove_at(1);
            end
            imh_pkg::CMD_DEL_HND:
            begin
                if (!handle_live(h))
                    r.status = imh_pkg::ST_DEAD;
                else
                    remove_at(hnd_slot[h]);
            end
            imh_pkg::CMD_MODIFY:
            begin
                if (!handle_live(h))
                    r.status = imh_pkg::ST_DEAD;
                else
                begin
                    s = hnd_slot[h];
                    heap_val[s] = int'(c.value);
                    sink(s);
                    swim(s);
                end
            end
            default:
            begin
                if (heap_count == 0)
                    r.status = imh_pkg::ST_EMPTY;
            end
        endcase
        r.min_value     = heap_count != 0 ? heap_val[1] : 0;
        r.is_empty      = heap_count == 0;
        r.element_count = 11'(heap_count);
        return r;
    endfunction

    // one command transaction, sender idles in bursts
    task automatic send_cmd(logic [2:0] op, int h, int v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 3) == 1 ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                cmd       <= imh_pkg::cmd_t'({$urandom, 16'($urandom)});
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        cmd_valid      <= 1'b1;
        cmd.command    <= op;
        cmd.handle     <= 13'(h);
        cmd.value      <= v;
        forever
        begin
            @(posedge clk);
            if (!cmd_stall)
                break;
        end
        expected_rsp_q.push_back(heap_apply(cmd));
    endtask

    task automatic wait_drained();
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 16) - 8;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_handle();
        int h;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 8191);
        for (int i = 0; i < 8; i++)
        begin
            h = $urandom_range(1, last_handle > 0 ? last_handle : 1);
            if (hnd_live[h])
                return h;
        end
        return h;
    endfunction

    task automatic test_directed();
        send_cmd(imh_pkg::CMD_PEEK, 0, 0);
        send_cmd(imh_pkg::CMD_DEL_MIN, 0, 0);
        send_cmd(imh_pkg::CMD_DEL_HND, 0, 0);
        send_cmd(imh_pkg::CMD_MODIFY, 1, 5);
        send_cmd(imh_pkg::CMD_INSERT, 8191, 32'h7fffffff);
        send_cmd(imh_pkg::CMD_INSERT, 0, 32'h80000000);
        send_cmd(imh_pkg::CMD_INSERT, 0, 0);
        send_cmd(imh_pkg::CMD_INSERT, 0, -1);
        send_cmd(imh_pkg::CMD_PEEK, 0, 0);
        send_cmd(3'd7, 0, 0);
        send_cmd(3'd5, 8191, 32'hffffffff);
        send_cmd(imh_pkg::CMD_MODIFY, 1, 32'h80000000);
        send_cmd(imh_pkg::CMD_MODIFY, 2, 32'h7fffffff);
        send_cmd(imh_pkg::CMD_DEL_HND, 0, 0);
        send_cmd(imh_pkg::CMD_DEL_HND, imh_pkg::MAX_HANDLES, 0);
        send_cmd(imh_pkg::CMD_MODIFY, imh_pkg::MAX_HANDLES + 1, 0);
        send_cmd(imh_pkg::CMD_MODIFY, 8191, 0);
        send_cmd(imh_pkg::CMD_DEL_HND, 2, 0);      // last slot, no sift
        send_cmd(imh_pkg::CMD_DEL_HND, 2, 0);      // now dead
        send_cmd(imh_pkg::CMD_DEL_MIN, 0, 0);
        send_cmd(imh_pkg::CMD_DEL_MIN, 0, 0);
        send_cmd(imh_pkg::CMD_DEL_MIN, 0, 0);
        send_cmd(imh_pkg::CMD_DEL_MIN, 0, 0);
        send_cmd(3'd6, 0, 0);
    endtask

    task automatic test_random(int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                send_cmd(imh_pkg::CMD_INSERT, $urandom_range(0, 8191), pick_value());
            else if (sel < 55)
                send_cmd(imh_pkg::CMD_DEL_MIN, $urandom_range(0, 8191), $urandom);
            else if (sel < 70)
                send_cmd(imh_pkg::CMD_DEL_HND, pick_handle(), $urandom);
            else if (sel < 87)
                send_cmd(imh_pkg::CMD_MODIFY, pick_handle(), pick_value());
            else if (sel < 95)
                send_cmd(imh_pkg::CMD_PEEK, $urandom_range(0, 8191), $urandom);
            else
                send_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 8191), $urandom);
        end
    endtask

    task automatic test_fill_capacity();
        while (heap_count < imh_pkg::HEAP_CAPACITY)
            send_cmd(imh_pkg::CMD_INSERT, 0, pick_value());
        send_cmd(imh_pkg::CMD_INSERT, 0, 1);
        send_cmd(imh_pkg::CMD_MODIFY, pick_handle(), 32'h80000000);
        send_cmd(imh_pkg::CMD_DEL_HND, pick_handle(), 0);
        test_random(40);
    endtask

    // receiver stall pattern: a randomly chosen mode, re-chosen when its random run ends
    initial
    begin
        int mode;
        int left;
        rsp_stall = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= $urandom_range(0, 2) == 0;
                2: rsp_stall <= $urandom_range(0, 7) != 0;
                default: rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
            endcase
        end
    end

    // response checker and idle watchdog
    initial
    begin
        imh_pkg::rsp_t want;
        mismatches  = 0;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            idle_cycles++;
            if (cmd_valid && !cmd_stall)
                idle_cycles = 0;
            if (rsp_valid && !rsp_stall)
            begin
                idle_cycles = 0;
                if (expected_rsp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response transaction %p", rsp);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, rsp);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("indexed_min_heap_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        heap_count  = 0;
        last_handle = 0;
        burst_left  = 0;
        for (int i = 0; i <= imh_pkg::MAX_HANDLES; i++)
            hnd_live[i] = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(60);
        test_fill_capacity();

        @(negedge clk);
        cmd_valid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_rsp_q.size() == 0)
            $display("indexed_min_heap_core verification clean");
        else
            $display("indexed_min_heap_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/imh_pkg.sv
rtl/imh_ram.sv
rtl/indexed_min_heap_core.sv
verif/indexed_min_heap_core_test.sv
